/* rtl/core/bcdt_pkg.sv */
// bcdt_pkg: shared types, constants and the seven-segment lookup for the
// bcd countdown timer core. No dependencies; used by every core module.
`default_nettype none

package bcdt_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 7;
    localparam int KIND_W     = 2;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int SEGS_W     = NUM_DIGITS * SEG_W;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // item kinds carried in tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_START = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [SEG_W-1:0]   seg_t;

    // wrap value on borrow, index 0 is centiseconds
    localparam digit_t WRAP_TO [NUM_DIGITS] = '{4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd9};

    // per-transaction control handed to every cell
    typedef struct packed {
        logic clear;   // zero the digit (clear key or countdown ran out)
        logic shift;   // take the neighbour's digit (digit key)
        logic tick;    // countdown step, qualified by the borrow chain
    } cell_ctrl_t;

    // bit6 top, bit5 upper left, bit4 upper right, bit3 middle,
    // bit2 lower left, bit1 lower right, bit0 bottom
    function automatic seg_t seg_of(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 7'h77;
            4'd1:    s = 7'h12;
            4'd2:    s = 7'h5D;
            4'd3:    s = 7'h5B;
            4'd4:    s = 7'h3A;
            4'd5:    s = 7'h6B;
            4'd6:    s = 7'h6F;
            4'd7:    s = 7'h52;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7A;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bcdt_digit_cell.sv */
// bcdt_digit_cell: one bcd digit of the countdown chain, with its borrow,
// shift-in from the lower neighbour and segment pattern. Depends on bcdt_pkg.
`default_nettype none

module bcdt_digit_cell
    import bcdt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire digit_t     wrap_val,
    input  wire digit_t     shift_in,
    input  wire logic       borrow_in,
    output logic            borrow_out,
    output digit_t          digit_q,
    output digit_t          digit_next,
    output seg_t            seg_next
);

    digit_t digit_reg;
    logic   is_zero;

    assign is_zero    = (digit_reg == '0);
    // borrow ripples up only through zero digits
    assign borrow_out = borrow_in & is_zero;
    assign digit_q    = digit_reg;

    // next digit value for this transaction
    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.shift) begin
            digit_next = shift_in;
        end else if (ctrl.tick && borrow_in) begin
            digit_next = is_zero ? wrap_val : digit_reg - digit_t'(1);
        end
    end

    assign seg_next = seg_of(digit_next);

    // digit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bcd_countdown_timer_core.sv */
// bcd_countdown_timer_core: top level of the six-digit MM:SS.cc countdown
// timer. Depends on bcdt_pkg and bcdt_digit_cell.
//
// Usage:
//   Input stream (s_): one transaction per event. s_tuser[1:0] gives the
//   kind (tick of 10 ms, digit key, start, clear), s_tdata[3:0] the digit
//   for a digit key. Output stream (m_): exactly one transaction per input
//   transaction, in order, carrying the time digits, their segment
//   patterns, the running flag and the expired flag.
//   The result of a transaction is registered: it is presented on m_ right
//   after the edge at which the transaction is accepted.
//   Throughput is one transaction per cycle while results are taken,
//   set by the combinational borrow ripple through the six digit cells.
//   The result sits in an output register; s_tready is high whenever that
//   register is empty or is being emptied in the same cycle, so a stalled
//   receiver holds the result and stops further input until it is taken.
//   Reset (aresetn low, synchronous) zeroes all digits, stops the
//   countdown and empties the output register.
`default_nettype none

module bcd_countdown_timer_core
    import bcdt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // result transactions
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [23:0] time_bcd, [65:24] segments,
                                        // [66] running_now, [67] expired,
                                        // [71:68] zero
);

    logic       s_fire;
    kind_t      kind;
    digit_t     key_digit;
    logic       counting_reg, counting_next;
    logic       expire;
    cell_ctrl_t ctrl;

    digit_t digit_q    [NUM_DIGITS];
    digit_t digit_next [NUM_DIGITS];
    seg_t   seg_next   [NUM_DIGITS];
    logic   borrow     [NUM_DIGITS+1];

    logic               m_tvalid_reg;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [SEGS_W-1:0]  segs_reg, segs_next;
    logic               run_reg;
    logic               exp_reg;

    // handshake
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign kind      = kind_t'(s_tuser[1:0]);
    assign key_digit = s_tdata[DIGIT_W-1:0];

    // countdown runs out when every digit is zero on a running tick
    assign borrow[0] = 1'b1;
    assign expire    = s_fire && (kind == KIND_TICK) && counting_reg && borrow[NUM_DIGITS];

    // control for the cell row
    always_comb begin
        ctrl.clear = s_fire && ((kind == KIND_CLEAR) || expire);
        ctrl.shift = s_fire && (kind == KIND_DIGIT) && !counting_reg &&
                     (key_digit <= DIGIT_MAX);
        ctrl.tick  = s_fire && (kind == KIND_TICK) && counting_reg;
    end

    // row of digit cells, centiseconds at index 0
    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
        digit_t shift_src;
        if (k == 0) begin : g_first
            assign shift_src = key_digit;
        end else begin : g_rest
            assign shift_src = digit_q[k-1];
        end

        bcdt_digit_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .wrap_val   (WRAP_TO[k]),
            .shift_in   (shift_src),
            .borrow_in  (borrow[k]),
            .borrow_out (borrow[k+1]),
            .digit_q    (digit_q[k]),
            .digit_next (digit_next[k]),
            .seg_next   (seg_next[k])
        );

        assign bcd_next[k*DIGIT_W +: DIGIT_W] = digit_next[k];
        assign segs_next[k*SEG_W +: SEG_W]    = seg_next[k];
    end

    // run flag next value
    always_comb begin
        counting_next = counting_reg;
        if (s_fire) begin
            case (kind)
                KIND_START: counting_next = 1'b1;
                KIND_CLEAR: counting_next = 1'b0;
                KIND_TICK:  counting_next = expire ? 1'b0 : counting_reg;
                KIND_DIGIT: counting_next = counting_reg;
                default:    counting_next = counting_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counting_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            counting_reg <= counting_next;
            if (s_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            bcd_reg  <= bcd_next;
            segs_reg <= segs_next;
            run_reg  <= counting_next;
            exp_reg  <= expire;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, exp_reg, run_reg, segs_reg, bcd_reg};

endmodule

`default_nettype wire

/* tb/bcd_countdown_timer_core_tb.sv */
// bcd_countdown_timer_core_tb: self-checking testbench for the MM:SS.cc countdown
// timer core; directed table then random event sequences, checked by a predictor.
// Depends on bcdt_pkg and the bcd_countdown_timer_core rtl only.

module bcd_countdown_timer_core_tb;
    import bcdt_pkg::*;

    localparam int ITEM_TARGET    = 1250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int SEC_TENS       = 3;
    localparam int ROW_COUNT      = 24;

    // segment patterns per digit, bit6 top down to bit0 bottom
    localparam logic [SEG_W-1:0] SEG_ROM [10] = '{
        7'h77, 7'h12, 7'h5D, 7'h5B, 7'h3A, 7'h6B, 7'h6F, 7'h52, 7'h7F, 7'h7A
    };

    // one result transaction, laid out as m_tdata[67:0]
    typedef struct packed {
        logic              expired;
        logic              running;
        logic [SEGS_W-1:0] segments;
        logic [BCD_W-1:0]  time_bcd;
    } timer_result_t;

    // hand-written expectation attached to a directed row
    typedef struct packed {
        logic             known;
        logic [BCD_W-1:0] time_bcd;
        logic             running;
        logic             expired;
    } typed_note_t;

    typedef struct packed {
        kind_t        kind;
        digit_t       digit;
        typed_note_t  note;
    } timer_row_t;

    localparam typed_note_t NO_NOTE = '0;

    // directed events: idle tick, start at zero, ignored keys, all nines, borrows, clear
    localparam timer_row_t DIRECTED [ROW_COUNT] = '{
        '{KIND_TICK,  4'd0,  '{1'b1, 24'h000000, 1'b0, 1'b0}},
        '{KIND_START, 4'd5,  '{1'b1, 24'h000000, 1'b1, 1'b0}},
        '{KIND_TICK,  4'd15, '{1'b1, 24'h000000, 1'b0, 1'b1}},
        '{KIND_DIGIT, 4'd9,  '{1'b1, 24'h000009, 1'b0, 1'b0}},
        '{KIND_DIGIT, 4'd15, '{1'b1, 24'h000009, 1'b0, 1'b0}},
        '{KIND_DIGIT, 4'd10, '{1'b1, 24'h000009, 1'b0, 1'b0}},
        '{KIND_DIGIT, 4'd9,  NO_NOTE},
        '{KIND_DIGIT, 4'd9,  NO_NOTE},
        '{KIND_DIGIT, 4'd9,  NO_NOTE},
        '{KIND_DIGIT, 4'd9,  NO_NOTE},
        '{KIND_DIGIT, 4'd9,  '{1'b1, 24'h999999, 1'b0, 1'b0}},
        '{KIND_START, 4'd0,  '{1'b1, 24'h999999, 1'b1, 1'b0}},
        '{KIND_DIGIT, 4'd3,  '{1'b1, 24'h999999, 1'b1, 1'b0}},
        '{KIND_START, 4'd12, '{1'b1, 24'h999999, 1'b1, 1'b0}},
        '{KIND_TICK,  4'd0,  NO_NOTE},
        '{KIND_CLEAR, 4'd15, '{1'b1, 24'h000000, 1'b0, 1'b0}},
        '{KIND_DIGIT, 4'd1,  NO_NOTE},
        '{KIND_DIGIT, 4'd0,  NO_NOTE},
        '{KIND_DIGIT, 4'd0,  NO_NOTE},
        '{KIND_DIGIT, 4'd0,  NO_NOTE},
        '{KIND_DIGIT, 4'd0,  NO_NOTE},
        '{KIND_START, 4'd7,  NO_NOTE},
        '{KIND_TICK,  4'd8,  NO_NOTE},
        '{KIND_CLEAR, 4'd0,  '{1'b1, 24'h000000, 1'b0, 1'b0}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [3:0] digit, [7:4] zero
    logic [1:0]  s_tuser  = '0;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [23:0] time_bcd, [65:24] segments,
                                  // [66] running_now, [67] expired, [71:68] zero

    // predictor state
    digit_t        shown_digits [NUM_DIGITS];
    logic          countdown_on;
    timer_result_t pending_results [$];
    typed_note_t   typed_notes [$];

    int error_count  = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int s_calm_left  = 0;
    bit s_calm       = 1'b0;

    bcd_countdown_timer_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // segment patterns for six bcd digits, same digit order
    function automatic logic [SEGS_W-1:0] segments_of(input logic [BCD_W-1:0] bcd);
        logic [SEGS_W-1:0] segs;
        digit_t            d;
        segs = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            segs[i*SEG_W +: SEG_W] = (d <= 4'd9) ? SEG_ROM[d] : '0;
        end
        return segs;
    endfunction

    // apply one event to the predicted timer and form its result
    task automatic advance_timer(input kind_t kind, input digit_t digit,
                                 output timer_result_t res);
        logic             borrowing;
        logic             ran_out;
        logic [BCD_W-1:0] bcd;
        ran_out = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (countdown_on) begin
                    // ripple the borrow up from the centiseconds
                    borrowing = 1'b1;
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (borrowing) begin
                            if (shown_digits[i] != 4'd0) begin
                                shown_digits[i] = shown_digits[i] - 4'd1;
                                borrowing = 1'b0;
                            end else begin
                                shown_digits[i] = (i == SEC_TENS) ? 4'd5 : 4'd9;
                            end
                        end
                    end
                    if (borrowing) begin
                        foreach (shown_digits[i]) shown_digits[i] = 4'd0;
                        countdown_on = 1'b0;
                        ran_out = 1'b1;
                    end
                end
            end
            KIND_DIGIT: begin
                // keys only land while idle and only for real digits
                if (!countdown_on && digit <= 4'd9) begin
                    for (int i = NUM_DIGITS - 1; i > 0; i--)
                        shown_digits[i] = shown_digits[i-1];
                    shown_digits[0] = digit;
                end
            end
            KIND_START: begin
                countdown_on = 1'b1;
            end
            default: begin
                foreach (shown_digits[i]) shown_digits[i] = 4'd0;
                countdown_on = 1'b0;
            end
        endcase
        for (int i = 0; i < NUM_DIGITS; i++)
            bcd[i*DIGIT_W +: DIGIT_W] = shown_digits[i];
        res.time_bcd = bcd;
        res.segments = segments_of(bcd);
        res.running  = countdown_on;
        res.expired  = ran_out;
    endtask

    // present one event after a random gap and hold it until taken
    task automatic send_event(input kind_t kind, input digit_t digit, input typed_note_t note);
        int gap;
        if (s_calm_left == 0) begin
            s_calm      = ($urandom_range(0, 2) == 0);
            s_calm_left = $urandom_range(20, 80);
        end
        s_calm_left--;
        gap = s_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        typed_notes.push_back(note);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, digit};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_noise();
        send_event(kind_t'($urandom_range(0, 3)), digit_t'($urandom_range(0, 15)), NO_NOTE);
    endtask

    // predict on input transactions, check on result transactions
    always @(posedge aclk) begin : monitor
        timer_result_t want;
        timer_result_t got;
        typed_note_t   note;
        if (!aresetn) begin
            foreach (shown_digits[i]) shown_digits[i] = 4'd0;
            countdown_on = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[67:0];
                if (pending_results.size() == 0) begin
                    error_count++;
                    $error("result with nothing expected: %h", m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got.time_bcd !== want.time_bcd) begin
                        error_count++;
                        $error("time_bcd: expected %h, got %h", want.time_bcd, got.time_bcd);
                    end
                    if (got.segments !== want.segments) begin
                        error_count++;
                        $error("segments: expected %h, got %h", want.segments, got.segments);
                    end
                    if (got.running !== want.running) begin
                        error_count++;
                        $error("running_now: expected %b, got %b", want.running, got.running);
                    end
                    if (got.expired !== want.expired) begin
                        error_count++;
                        $error("expired: expected %b, got %b", want.expired, got.expired);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_timer(kind_t'(s_tuser), s_tdata[3:0], want);
                note = (typed_notes.size() != 0) ? typed_notes.pop_front() : NO_NOTE;
                // directed rows carry their own hand-read expectation
                if (note.known) begin
                    want.time_bcd = note.time_bcd;
                    want.segments = segments_of(note.time_bcd);
                    want.running  = note.running;
                    want.expired  = note.expired;
                end
                pending_results.push_back(want);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure, with calm stretches
    initial begin : receiver
        int gap;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm      = 1'b0;
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 80);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : stimulus
        int     pick;
        int     count;
        int     preset;
        int     ticks;
        digit_t d;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int r = 0; r < ROW_COUNT; r++)
            send_event(DIRECTED[r].kind, DIRECTED[r].digit, DIRECTED[r].note);

        // random event sequences
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_noise();
            end else if (pick < 65) begin
                // short countdown, often run out to expiry
                send_event(KIND_CLEAR, digit_t'($urandom_range(0, 15)), NO_NOTE);
                count  = $urandom_range(1, 2);
                preset = 0;
                for (int k = 0; k < count; k++) begin
                    d = (count == 2 && k == 0) ? digit_t'($urandom_range(0, 3))
                                               : digit_t'($urandom_range(0, 9));
                    preset = preset * 10 + int'(d);
                    send_event(KIND_DIGIT, d, NO_NOTE);
                end
                send_event(KIND_START, digit_t'($urandom_range(0, 15)), NO_NOTE);
                ticks = $urandom_range(0, 1) ? preset + 1 + $urandom_range(0, 2)
                                             : $urandom_range(0, preset);
                for (int t = 0; t < ticks; t++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_noise();
                    send_event(KIND_TICK, digit_t'($urandom_range(0, 15)), NO_NOTE);
                end
            end else begin
                // sparse six-digit preset so borrows ripple into the high digits
                if ($urandom_range(0, 3) != 0)
                    send_event(KIND_CLEAR, digit_t'($urandom_range(0, 15)), NO_NOTE);
                for (int k = 0; k < NUM_DIGITS; k++) begin
                    d = $urandom_range(0, 1) ? 4'd0 : digit_t'($urandom_range(0, 9));
                    send_event(KIND_DIGIT, d, NO_NOTE);
                end
                send_event(KIND_START, digit_t'($urandom_range(0, 15)), NO_NOTE);
                ticks = $urandom_range(1, 6);
                for (int t = 0; t < ticks; t++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_event(KIND_DIGIT, digit_t'($urandom_range(0, 15)), NO_NOTE);
                    send_event(KIND_TICK, digit_t'($urandom_range(0, 15)), NO_NOTE);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding results
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* bcd_countdown_timer_core.f */
rtl/core/bcdt_pkg.sv
rtl/core/bcdt_digit_cell.sv
rtl/core/bcd_countdown_timer_core.sv
tb/bcd_countdown_timer_core_tb.sv
